// ===== rtl/sufe_pkg.sv =====
package sufe_pkg;

	localparam int unsigned BP_W  = 16;
	localparam int unsigned TO_W  = 24;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned OUT_W = 8;

	localparam logic [IDX_W-1:0] CFG_BIT_PERIOD   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

	localparam logic [BP_W-1:0] BIT_PERIOD_RESET   = 16'd182;
	localparam logic [TO_W-1:0] IDLE_TIMEOUT_RESET = 24'd65535;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_START,
		RX_DATA
	} rx_phase_t;

	typedef enum logic [2:0] {
		TX_IDLE,
		TX_START,
		TX_DATA,
		TX_STOP,
		TX_EXTRA
	} tx_phase_t;

endpackage

// ===== rtl/sufe_if.sv =====
interface sufe_in_if;
	logic valid;
	logic ready;
	logic rx_level;

	modport source (output valid, output rx_level, input ready);
	modport sink (input valid, input rx_level, output ready);
endinterface

interface sufe_out_if;
	logic       valid;
	logic       ready;
	logic       tx_level;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] stored_count;
	logic       flushing;
	logic       overflow;

	modport source (
		output valid, output tx_level, output rx_valid, output rx_data,
		output stored_count, output flushing, output overflow, input ready
	);
	modport sink (
		input valid, input tx_level, input rx_valid, input rx_data,
		input stored_count, input flushing, input overflow, output ready
	);
endinterface

// ===== rtl/soft_uart_idle_flush_echo_unit.sv =====
// Channel   Direction  Payload
// sample    in         rx_level: receive line level for one tick
// report    out        tx_level, rx_valid, rx_data, stored_count, flushing, overflow
// cfg       in         cfg_we, cfg_index, cfg_data: plain register write
//
// One request is taken per cycle unless stalled, its report ready at the next edge.
// Bytes sit in a BUF_DEPTH entry memory, read into a register before the data bits.
// Reset clears control state; byte memory and data registers start uninitialised.
// A stalled report holds the sample channel until it is taken.
module soft_uart_idle_flush_echo_unit
	import sufe_pkg::*;
#(
	parameter int unsigned DATA_BITS = 8,
	parameter int unsigned BUF_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	sufe_in_if.sink             sample,
	sufe_out_if.source          report
);

	localparam int unsigned AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(BUF_DEPTH + 1);
	localparam int unsigned BIW = $clog2(DATA_BITS);
	localparam logic [BIW-1:0] LAST_BIT = BIW'(DATA_BITS - 1);
	localparam logic [CW-1:0]  DEPTH_C  = CW'(BUF_DEPTH);

	logic [BP_W-1:0] bit_period_q;
	logic [TO_W-1:0] idle_timeout_q;

	rx_phase_t          rx_phase_q, rx_phase_d;
	logic               rx_prev_q;
	logic [BP_W-1:0]    rx_tick_q, rx_tick_d;
	logic [BIW-1:0]     rx_bit_q, rx_bit_d;
	logic [DATA_BITS-1:0] rx_shift_q, rx_shift_d;
	logic [TO_W-1:0]    idle_count_q, idle_count_d;
	logic               idle_expired_q, idle_expired_d;
	logic [CW-1:0]      wc_q, wc_w, wc_d;
	logic [CW-1:0]      ri_q, ri_1, ri_d;
	tx_phase_t          tx_phase_q, tx_phase_1, tx_phase_d;
	logic [BP_W-1:0]    tx_tick_q, tx_tick_1, tx_tick_d;
	logic [BIW-1:0]     tx_bit_q, tx_bit_1, tx_bit_d;
	logic               overflow_q, overflow_d;

	logic [DATA_BITS-1:0] mem [BUF_DEPTH];
	logic [DATA_BITS-1:0] rd_data_q, fwd_data_q, tx_shift;
	logic                 fwd_hit_q;

	logic               accept;
	logic               level;
	logic [BP_W-1:0]    period, half, rx_tick_inc, tx_tick_inc;
	logic [TO_W-1:0]    timeout;
	logic               edge_seen, rx_done;
	logic [DATA_BITS-1:0] done_byte;
	logic               wr_en, rd_en, load;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               tx_level_c, flushing_c;
	logic [CW-1:0]      remain;

	logic               out_valid_q;
	logic               tx_level_q, rx_valid_q, flushing_q, overflow_out_q;
	logic [OUT_W-1:0]   rx_data_q, stored_count_q;

	assign sample.ready = !out_valid_q || report.ready;
	assign accept       = sample.valid && sample.ready;
	assign level        = sample.rx_level;

	assign period  = (bit_period_q == '0) ? BP_W'(1) : bit_period_q;
	assign half    = bit_period_q >> 1;
	assign timeout = (idle_timeout_q == '0) ? TO_W'(1) : idle_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= BIT_PERIOD_RESET;
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIT_PERIOD:   bit_period_q   <= cfg_data[BP_W-1:0];
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data[TO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rx_phase_d  = rx_phase_q;
		rx_tick_d   = rx_tick_q;
		rx_bit_d    = rx_bit_q;
		rx_shift_d  = rx_shift_q;
		edge_seen   = 1'b0;
		rx_done     = 1'b0;
		done_byte   = rx_shift_q;
		rx_tick_inc = rx_tick_q + BP_W'(1);
		unique case (rx_phase_q)
			RX_IDLE: begin
				if (rx_prev_q && !level) begin
					edge_seen  = 1'b1;
					rx_tick_d  = '0;
					rx_bit_d   = '0;
					rx_shift_d = '0;
					rx_phase_d = (half == '0) ? RX_DATA : RX_START;
				end
			end
			RX_START: begin
				if (rx_tick_inc >= half) begin
					rx_tick_d  = '0;
					rx_phase_d = RX_DATA;
				end else begin
					rx_tick_d = rx_tick_inc;
				end
			end
			RX_DATA: begin
				if (rx_tick_inc >= period) begin
					rx_tick_d            = '0;
					done_byte[rx_bit_q]  = level;
					if (rx_bit_q == LAST_BIT) begin
						rx_done    = 1'b1;
						rx_phase_d = RX_IDLE;
						rx_bit_d   = '0;
						rx_shift_d = '0;
					end else begin
						rx_bit_d   = rx_bit_q + BIW'(1);
						rx_shift_d = done_byte;
					end
				end else begin
					rx_tick_d = rx_tick_inc;
				end
			end
			default: rx_phase_d = RX_IDLE;
		endcase
	end

	assign wr_en      = accept && rx_done && (wc_q < DEPTH_C);
	assign wr_addr    = wc_q[AW-1:0];
	assign wc_w       = (rx_done && (wc_q < DEPTH_C)) ? wc_q + CW'(1) : wc_q;
	assign overflow_d = overflow_q || (rx_done && (wc_q == DEPTH_C));

	assign load    = (tx_phase_q == TX_IDLE) && (ri_q < wc_w) && ((ri_q != '0) || idle_expired_q);
	assign rd_en   = accept && load;
	assign rd_addr = ri_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= done_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= done_byte;
		end
	end

	assign tx_shift = fwd_hit_q ? fwd_data_q : rd_data_q;

	always_comb begin
		tx_phase_1  = load ? TX_START : tx_phase_q;
		tx_tick_1   = load ? '0 : tx_tick_q;
		tx_bit_1    = load ? '0 : tx_bit_q;
		ri_1        = load ? ri_q + CW'(1) : ri_q;
		tx_phase_d  = tx_phase_1;
		tx_tick_d   = tx_tick_1;
		tx_bit_d    = tx_bit_1;
		tx_tick_inc = tx_tick_1 + BP_W'(1);
		if (tx_phase_1 != TX_IDLE) begin
			if (tx_tick_inc >= period) begin
				tx_tick_d = '0;
				unique case (tx_phase_1)
					TX_START: begin
						tx_phase_d = TX_DATA;
						tx_bit_d   = '0;
					end
					TX_DATA: begin
						if (tx_bit_1 == LAST_BIT) begin
							tx_phase_d = TX_STOP;
						end else begin
							tx_bit_d = tx_bit_1 + BIW'(1);
						end
					end
					TX_STOP: tx_phase_d = TX_EXTRA;
					default: tx_phase_d = TX_IDLE;
				endcase
			end else begin
				tx_tick_d = tx_tick_inc;
			end
		end
		ri_d = ri_1;
		wc_d = wc_w;
		if ((tx_phase_d == TX_IDLE) && (ri_1 != '0) && (ri_1 >= wc_w)) begin
			ri_d = '0;
			wc_d = '0;
		end
	end

	always_comb begin
		unique case (tx_phase_1)
			TX_START: tx_level_c = 1'b0;
			TX_DATA:  tx_level_c = tx_shift[tx_bit_1];
			default:  tx_level_c = 1'b1;
		endcase
		flushing_c = (tx_phase_d != TX_IDLE) || ((ri_1 != '0) && (ri_1 < wc_w));
		remain     = wc_d - ri_d;
	end

	always_comb begin
		idle_count_d   = idle_count_q;
		idle_expired_d = idle_expired_q;
		if (edge_seen) begin
			idle_count_d   = '0;
			idle_expired_d = 1'b0;
		end else if (!idle_expired_q) begin
			idle_count_d = idle_count_q + TO_W'(1);
			if (idle_count_d >= timeout) begin
				idle_expired_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q     <= RX_IDLE;
			rx_prev_q      <= 1'b1;
			rx_tick_q      <= '0;
			rx_bit_q       <= '0;
			rx_shift_q     <= '0;
			idle_count_q   <= '0;
			idle_expired_q <= 1'b1;
			wc_q           <= '0;
			ri_q           <= '0;
			tx_phase_q     <= TX_IDLE;
			tx_tick_q      <= '0;
			tx_bit_q       <= '0;
			overflow_q     <= 1'b0;
		end else if (accept) begin
			rx_phase_q     <= rx_phase_d;
			rx_prev_q      <= level;
			rx_tick_q      <= rx_tick_d;
			rx_bit_q       <= rx_bit_d;
			rx_shift_q     <= rx_shift_d;
			idle_count_q   <= idle_count_d;
			idle_expired_q <= idle_expired_d;
			wc_q           <= wc_d;
			ri_q           <= ri_d;
			tx_phase_q     <= tx_phase_d;
			tx_tick_q      <= tx_tick_d;
			tx_bit_q       <= tx_bit_d;
			overflow_q     <= overflow_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_level_q     <= tx_level_c;
			rx_valid_q     <= rx_done;
			rx_data_q      <= rx_done ? OUT_W'(done_byte) : '0;
			stored_count_q <= OUT_W'(remain);
			flushing_q     <= flushing_c;
			overflow_out_q <= overflow_d;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.tx_level     = tx_level_q;
	assign report.rx_valid     = rx_valid_q;
	assign report.rx_data      = rx_data_q;
	assign report.stored_count = stored_count_q;
	assign report.flushing     = flushing_q;
	assign report.overflow     = overflow_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= DEPTH_C)
		else $error("Byte count exceeds buffer depth.");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ri_q <= wc_q)
		else $error("Read index has passed the write count.");

	a_frame_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_phase_q != TX_IDLE) |-> (ri_q != '0))
		else $error("A frame is being sent with no byte taken from the buffer.");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("Overflow flag cleared without reset.");
`endif

endmodule
